FILE: sv/bpe_pkg.sv
// Shared constants, types and stage control for the basis projection engine.
`default_nettype none
package bpe_pkg;

	localparam int MAX_LEN     = 512;
	localparam int MAX_COEFF   = 16;
	localparam int SAMPLE_BITS = 16;

	localparam int BASIS_W = 16;
	localparam int ACC_W   = 48;
	localparam int PROD_W  = SAMPLE_BITS + BASIS_W;
	localparam int ROW_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CNT_W   = $clog2(MAX_LEN + 1);
	localparam int LANE_W  = (MAX_COEFF > 1) ? $clog2(MAX_COEFF) : 1;

	localparam int NCOEFF_REG_W = 5;
	localparam int VLEN_REG_W   = 10;
	localparam int CFG_DATA_W   = 10;

	typedef enum logic [0:0] {
		REG_NUM_COEFF     = 1'b0,
		REG_VECTOR_LENGTH = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		FUNC_LOAD   = 1'b0,
		FUNC_SAMPLE = 1'b1
	} func_t;

	typedef logic [MAX_COEFF-1:0][BASIS_W-1:0] basis_row_t;
	typedef logic [MAX_COEFF-1:0][ACC_W-1:0]   acc_vec_t;

	// Per-beat control travelling down the sample pipeline.
	typedef struct packed {
		logic valid;   // a sample beat occupies the stage
		logic acc;     // sample is inside vector_length and is summed
		logic last;    // sample closes the vector
		logic err;     // some sample of this vector was dropped
	} stage_ctl_t;

	// Vector close event handed to the result bank.
	typedef struct packed {
		logic close;
		logic err;
	} close_t;

endpackage
`default_nettype wire

FILE: sv/bpe_basis_store.sv
// Basis store: one row per sample position, one lane per basis vector.
`default_nettype none
module bpe_basis_store (
	input  wire logic                           clk,
	input  wire logic                           wr_en,
	input  wire logic [bpe_pkg::ROW_W-1:0]      wr_row,
	input  wire logic [bpe_pkg::LANE_W-1:0]     wr_lane,
	input  wire logic [bpe_pkg::BASIS_W-1:0]    wr_data,
	input  wire logic                           rd_en,
	input  wire logic [bpe_pkg::ROW_W-1:0]      rd_row,
	output      bpe_pkg::basis_row_t            rd_data
);
	import bpe_pkg::*;

	basis_row_t mem [MAX_LEN];

	// lane-masked write, whole-row registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row][wr_lane] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_row];
		end
	end

endmodule
`default_nettype wire

FILE: sv/bpe_mac_array.sv
// Parallel multiply lanes and per-coefficient accumulators.
`default_nettype none
module bpe_mac_array (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire bpe_pkg::stage_ctl_t                 ctl_s1,
	input  wire logic signed [bpe_pkg::SAMPLE_BITS-1:0] sample_s1,
	input  wire bpe_pkg::basis_row_t                 row_s1,
	output      bpe_pkg::acc_vec_t                   sums,
	output      bpe_pkg::close_t                     done
);
	import bpe_pkg::*;

	stage_ctl_t                             ctl_s2;
	logic signed [PROD_W-1:0]               prod_s2 [MAX_COEFF];
	acc_vec_t                               acc_q;
	acc_vec_t                               acc_next;

	// stage 2: one product per lane
	always_ff @(posedge clk) begin
		for (int c = 0; c < MAX_COEFF; c++) begin
			prod_s2[c] <= sample_s1 * $signed(row_s1[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_comb begin
		for (int c = 0; c < MAX_COEFF; c++) begin
			if (ctl_s2.valid && ctl_s2.acc) begin
				acc_next[c] = acc_q[c]
					+ {{(ACC_W-PROD_W){prod_s2[c][PROD_W-1]}}, prod_s2[c]};
			end else begin
				acc_next[c] = acc_q[c];
			end
		end
	end

	// stage 3: accumulate; a closing beat hands the sums over and clears
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl_s2.valid && ctl_s2.last) begin
			acc_q <= '0;
		end else begin
			acc_q <= acc_next;
		end
	end

	assign sums       = acc_next;
	assign done.close = ctl_s2.valid && ctl_s2.last;
	assign done.err   = ctl_s2.err;

	a_clear_after_close: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s2.valid && ctl_s2.last) |=> (acc_q == '0))
		else $error("accumulators not cleared after vector close");
	a_drop_not_summed: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s2.valid && !ctl_s2.acc && !ctl_s2.last) |=> (acc_q == $past(acc_q)))
		else $error("dropped sample changed accumulators");
	a_drop_flags_err: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s2.valid && !ctl_s2.acc) |-> ctl_s2.err)
		else $error("dropped sample without overrun flag");

endmodule
`default_nettype wire

FILE: sv/basis_projection_engine_unit.sv
// Top level of the basis projection engine: front end, result bank, config.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------
//  item     | item_valid / item_ready    | func, basis_row, basis_col,
//           |                            | basis_value, sample, last_sample
//  result   | result_valid / result_ready| coefficient, coeff_index,
//           |                            | last_coeff, length_error
//  config   | cfg_we (no wait)           | cfg_index, cfg_wdata
//
// One item beat per cycle. A sample runs through three stages: basis row
// read, multiply lanes, accumulate. The last sample's sums are loaded into
// the result bank from the accumulate stage; the bank then drains one
// coefficient per accepted result beat (num_coeff beats). Item beats keep
// flowing while the bank drains; only a sample beat marked last_sample is
// held off while the previous vector is still in the pipeline or the bank.
// Reset clears config to 16 / 512, the accumulators, counters and flags; the
// basis store, the result bank and its error flag are not cleared.
`default_nettype none
module basis_projection_engine_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// item channel
	input  wire logic                                 item_valid,
	output      logic                                 item_ready,
	input  wire logic                                 func,
	input  wire logic [8:0]                           basis_row,
	input  wire logic [3:0]                           basis_col,
	input  wire logic signed [15:0]                   basis_value,
	input  wire logic signed [15:0]                   sample,
	input  wire logic                                 last_sample,
	// result channel
	output      logic                                 result_valid,
	input  wire logic                                 result_ready,
	output      logic signed [47:0]                   coefficient,
	output      logic [3:0]                           coeff_index,
	output      logic                                 last_coeff,
	output      logic                                 length_error,
	// config port
	input  wire logic                                 cfg_we,
	input  wire logic [0:0]                           cfg_index,
	input  wire logic [bpe_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
	import bpe_pkg::*;

	// config registers
	logic [NCOEFF_REG_W-1:0] num_coeff_q;
	logic [VLEN_REG_W-1:0]   vector_length_q;
	logic [LANE_W-1:0]       ncoeff_m1;
	logic [CNT_W-1:0]        vlen_eff;

	// front end
	logic [CNT_W-1:0]        sample_count_q;
	logic                    overrun_q;
	logic                    item_fire;
	logic                    is_sample;
	logic                    in_range;
	logic                    load_ok;
	logic                    end_busy;

	stage_ctl_t                          ctl_s1;
	logic signed [SAMPLE_BITS-1:0]       sample_s1;
	basis_row_t                          row_s1;

	acc_vec_t                sums;
	close_t                  done;

	// result bank
	acc_vec_t                bank_q;
	logic                    bank_err_q;
	logic                    bank_busy_q;
	logic [LANE_W-1:0]       out_idx_q;
	logic                    result_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_coeff_q     <= NCOEFF_REG_W'(MAX_COEFF);
			vector_length_q <= VLEN_REG_W'(MAX_LEN);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_NUM_COEFF:     num_coeff_q     <= cfg_wdata[NCOEFF_REG_W-1:0];
				REG_VECTOR_LENGTH: vector_length_q <= cfg_wdata[VLEN_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp registers into their usable ranges
	always_comb begin
		if (num_coeff_q == '0) begin
			ncoeff_m1 = '0;
		end else if (int'(num_coeff_q) > MAX_COEFF) begin
			ncoeff_m1 = LANE_W'(MAX_COEFF - 1);
		end else begin
			ncoeff_m1 = LANE_W'(num_coeff_q - NCOEFF_REG_W'(1));
		end
		if (vector_length_q == '0) begin
			vlen_eff = CNT_W'(1);
		end else if (int'(vector_length_q) > MAX_LEN) begin
			vlen_eff = CNT_W'(MAX_LEN);
		end else begin
			vlen_eff = CNT_W'(vector_length_q);
		end
	end

	// a closing beat waits until the previous vector has left the bank
	assign end_busy   = bank_busy_q || (ctl_s1.valid && ctl_s1.last) || done.close;
	assign item_ready = !((func_t'(func) == FUNC_SAMPLE) && last_sample && end_busy);
	assign item_fire  = item_valid && item_ready;
	assign is_sample  = func_t'(func) == FUNC_SAMPLE;
	assign in_range   = (sample_count_q < vlen_eff) && (int'(sample_count_q) < MAX_LEN);
	assign load_ok    = (int'(basis_row) < MAX_LEN) && (int'(basis_col) < MAX_COEFF);

	bpe_basis_store u_store (
		.clk     (clk),
		.wr_en   (item_fire && !is_sample && load_ok),
		.wr_row  (ROW_W'(basis_row)),
		.wr_lane (LANE_W'(basis_col)),
		.wr_data (basis_value),
		.rd_en   (item_fire && is_sample && in_range),
		.rd_row  (sample_count_q[ROW_W-1:0]),
		.rd_data (row_s1)
	);

	// sample count, overrun flag and stage-1 control of the vector being received
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= '0;
			overrun_q      <= 1'b0;
			ctl_s1         <= '0;
		end else begin
			ctl_s1.valid <= item_fire && is_sample;
			ctl_s1.acc   <= in_range;
			ctl_s1.last  <= last_sample;
			ctl_s1.err   <= overrun_q || !in_range;
			if (item_fire && is_sample) begin
				if (last_sample) begin
					sample_count_q <= '0;
					overrun_q      <= 1'b0;
				end else if (in_range) begin
					sample_count_q <= sample_count_q + CNT_W'(1);
				end else begin
					overrun_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire && is_sample) begin
			sample_s1 <= sample[SAMPLE_BITS-1:0];
		end
	end

	bpe_mac_array u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.sample_s1 (sample_s1),
		.row_s1    (row_s1),
		.sums      (sums),
		.done      (done)
	);

	// result bank: loaded on vector close, shifts one lane per result beat
	assign result_fire = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_busy_q <= 1'b0;
			out_idx_q   <= '0;
		end else if (done.close) begin
			bank_busy_q <= 1'b1;
			out_idx_q   <= '0;
		end else if (result_fire) begin
			if (out_idx_q == ncoeff_m1) begin
				bank_busy_q <= 1'b0;
			end
			out_idx_q <= out_idx_q + LANE_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (done.close) begin
			bank_q     <= sums;
			bank_err_q <= done.err;
		end else if (result_fire) begin
			bank_q <= bank_q >> ACC_W;
		end
	end

	assign result_valid = bank_busy_q;
	assign coefficient  = bank_q[0];
	assign coeff_index  = 4'(out_idx_q);
	assign last_coeff   = out_idx_q == ncoeff_m1;
	assign length_error = bank_err_q;

	a_close_into_free_bank: assert property (@(posedge clk) disable iff (!arst_n)
		done.close |-> !bank_busy_q)
		else $error("vector closed while result bank still draining");
	a_single_close_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl_s1.valid && ctl_s1.last && done.close))
		else $error("two vector closes in flight");
	a_drain_ends_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_fire && last_coeff) |=> !result_valid)
		else $error("result bank kept draining past last coefficient");
	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (out_idx_q <= ncoeff_m1))
		else $error("coefficient index beyond num_coeff");

endmodule
`default_nettype wire
